// ===== hdl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_W    = 36;  // physical page number width
  localparam int CNT_W     = 13;  // page count register width
  localparam int REQ_W     = 2;
  localparam int STS_W     = 2;
  localparam int CFG_IDX_W = 2;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INIT  = 2'd2;

  // result status
  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_FREE = 2'd1;
  localparam logic [STS_W-1:0] STS_RANGE   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_CNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number_res;
    logic [STS_W-1:0]  status;
  } res_t;

  typedef enum logic [2:0] {
    S_SWEEP,  // write every bitmap word (reset clear or init)
    S_IDLE,
    S_SCAN,   // allocate: stream words, find lowest clear bit
    S_FLOC,   // free: walk to the word holding the page
    S_FRD,    // free: read that word
    S_FWR,    // free: clear the bit and write back
    S_RESP    // hand result to the output register
  } state_e;

endpackage

// ===== hdl/bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page frame allocator over a bitmap held in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o   | bpa_pkg::req_t
//  out     | output    | out_valid_o / out_stall_i | bpa_pkg::res_t
//  cfg     | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
//  One request at a time; NW = ceil(MAX_PAGES / WORD_BITS) bitmap words.
//  Allocate: one RAM word read per cycle in the scan.
//  Free: walks the word base to the target word, then reads and writes it.
//  Init: one word written per cycle. Unknown request: plain ok response.
//  After reset all NW RAM words are cleared in a sweep; in_stall_o is high.
//  A finished word sits in the output register; a new request is taken
//  while it waits, and the next result holds until the register frees.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
  parameter int MAX_PAGES = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bpa_pkg::req_t                 in_word_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bpa_pkg::res_t                 out_word_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bpa_pkg::PAGE_W-1:0]    cfg_data_i
);
  import bpa_pkg::*;

  localparam int NWORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;   // RAM address
  localparam int WCNT_W = $clog2(NWORDS + 1);                  // word counter
  localparam int BIT_W  = $clog2(WORD_BITS);                   // bit in word
  localparam int BASE_W = $clog2(MAX_PAGES + WORD_BITS);       // page index
  localparam int CMP_W  = (BASE_W > CNT_W) ? BASE_W : CNT_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]  page_cnt_q, reserved_q;
  logic [PAGE_W-1:0] first_page_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_cnt_q   <= '0;
      first_page_q <= '0;
      reserved_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAGE_CNT:   page_cnt_q   <= cfg_data_i[CNT_W-1:0];
        CFG_FIRST_PAGE: first_page_q <= cfg_data_i;
        CFG_RESERVED:   reserved_q   <= cfg_data_i[CNT_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // counts clamped to the bitmap capacity
  logic [CMP_W-1:0]  num_ext, res_ext;
  logic [BASE_W-1:0] eff_pages, eff_res;

  assign num_ext   = CMP_W'(page_cnt_q);
  assign res_ext   = CMP_W'(reserved_q);
  assign eff_pages = (num_ext > CMP_W'(MAX_PAGES)) ? BASE_W'(MAX_PAGES)
                                                   : num_ext[BASE_W-1:0];
  assign eff_res   = (res_ext > CMP_W'(MAX_PAGES)) ? BASE_W'(MAX_PAGES)
                                                   : res_ext[BASE_W-1:0];

  // --------------------------------------------------------------------------
  // Bitmap RAM: one write port, one read port, registered read data
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] mem [NWORDS];
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // Control and datapath registers
  // --------------------------------------------------------------------------
  state_e               state_q, state_d;
  logic                 sweep_q, sweep_d;      // reset clear, no response
  logic [WCNT_W-1:0]    w_q, w_d;              // word walk / issue counter
  logic [BASE_W-1:0]    base_q, base_d;        // w_q * WORD_BITS
  logic [BASE_W-1:0]    lim_q, lim_d;          // page limit or reserve count
  logic [BASE_W-1:0]    idx_q, idx_d;          // page index to free
  logic                 chk_vld_q, chk_vld_d;  // rdata_q holds a scan word
  logic [AW-1:0]        chk_w_q, chk_w_d;
  logic [BASE_W-1:0]    chk_base_q, chk_base_d;
  res_t                 res_q, res_d;
  logic                 out_vld_q, out_vld_d;
  res_t                 out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWEEP;
      sweep_q   <= 1'b1;
      w_q       <= '0;
      base_q    <= '0;
      lim_q     <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      w_q       <= w_d;
      base_q    <= base_d;
      lim_q     <= lim_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    chk_w_q    <= chk_w_d;
    chk_base_q <= chk_base_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  // --------------------------------------------------------------------------
  // Shared decode
  // --------------------------------------------------------------------------
  logic                 accept, out_free, last_word, scan_stop;
  logic [BASE_W-1:0]    base_next, scan_idx, sweep_rem;
  logic [PAGE_W-1:0]    free_diff;
  logic                 free_ok;
  logic [BIT_W-1:0]     free_bit;
  logic                 ffz_found;
  logic [BIT_W-1:0]     ffz_idx;
  logic [WORD_BITS-1:0] ffz_onehot;
  logic [WORD_BITS-1:0] sweep_word;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_vld_q || !out_stall_i;
  assign base_next = base_q + BASE_W'(WORD_BITS);
  assign last_word = (w_q == WCNT_W'(NWORDS - 1));
  // scan ends past the last word or once the word base reaches the limit
  assign scan_stop = (w_q == WCNT_W'(NWORDS)) || (base_q >= lim_q);
  assign scan_idx  = chk_base_q + BASE_W'(ffz_idx);

  // free range check: first_page <= page < first_page + n
  assign free_diff = in_word_i.page_number - first_page_q;
  assign free_ok   = (in_word_i.page_number >= first_page_q) &&
                     (free_diff < PAGE_W'(eff_pages));
  assign free_bit  = BIT_W'(idx_q - base_q);

  // sweep pattern: ones below the reserve count, zeros above
  assign sweep_rem = lim_q - base_q;
  always_comb begin
    if (lim_q >= base_next) begin
      sweep_word = '1;
    end else if (lim_q > base_q) begin
      sweep_word = ~({WORD_BITS{1'b1}} << sweep_rem[BIT_W-1:0]);
    end else begin
      sweep_word = '0;
    end
  end

  bpa_ffz #(
    .WORD_BITS(WORD_BITS)
  ) u_ffz (
    .word_i  (rdata_q),
    .found_o (ffz_found),
    .idx_o   (ffz_idx),
    .onehot_o(ffz_onehot)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_SWEEP: begin
        if (last_word) state_d = sweep_q ? S_IDLE : S_RESP;
      end
      S_IDLE: begin
        if (accept) begin
          priority if (in_word_i.req_type == REQ_ALLOC) begin
            state_d = S_SCAN;
          end else if (in_word_i.req_type == REQ_FREE) begin
            state_d = free_ok ? S_FLOC : S_RESP;
          end else if (in_word_i.req_type == REQ_INIT) begin
            state_d = S_SWEEP;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if ((chk_vld_q && ffz_found) || (!chk_vld_q && scan_stop)) state_d = S_RESP;
      end
      S_FLOC: begin
        if (idx_q < base_next) state_d = S_FRD;
      end
      S_FRD:  state_d = S_FWR;
      S_FWR:  state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and RAM control
  // --------------------------------------------------------------------------
  always_comb begin
    sweep_d    = sweep_q;
    w_d        = w_q;
    base_d     = base_q;
    lim_d      = lim_q;
    idx_d      = idx_q;
    chk_vld_d  = 1'b0;
    chk_w_d    = chk_w_q;
    chk_base_d = chk_base_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    mem_we     = 1'b0;
    mem_waddr  = w_q[AW-1:0];
    mem_wdata  = sweep_word;
    mem_re     = 1'b0;
    mem_raddr  = w_q[AW-1:0];

    unique case (state_q)
      S_SWEEP: begin
        mem_we = 1'b1;
        w_d    = w_q + WCNT_W'(1);
        base_d = base_next;
        if (last_word) sweep_d = 1'b0;
      end
      S_IDLE: begin
        w_d    = '0;
        base_d = '0;
        res_d  = '{page_number_res: '0, status: STS_OK};
        if (accept) begin
          priority if (in_word_i.req_type == REQ_ALLOC) begin
            lim_d = eff_pages;
          end else if (in_word_i.req_type == REQ_FREE) begin
            idx_d = free_diff[BASE_W-1:0];
            if (!free_ok) res_d.status = STS_RANGE;
          end else if (in_word_i.req_type == REQ_INIT) begin
            lim_d = eff_res;
          end else begin
            lim_d = lim_q;  // unknown request: plain ok response
          end
        end
      end
      S_SCAN: begin
        // issue stage: one read per cycle until the limit
        if (!scan_stop) begin
          mem_re     = 1'b1;
          w_d        = w_q + WCNT_W'(1);
          base_d     = base_next;
          chk_vld_d  = 1'b1;
          chk_w_d    = w_q[AW-1:0];
          chk_base_d = base_q;
        end
        // check stage: word read last cycle
        if (chk_vld_q && ffz_found) begin
          chk_vld_d = 1'b0;
          if (scan_idx < lim_q) begin
            mem_we                = 1'b1;
            mem_waddr             = chk_w_q;
            mem_wdata             = rdata_q | ffz_onehot;
            res_d.page_number_res = first_page_q + PAGE_W'(scan_idx);
          end else begin
            res_d.status = STS_NO_FREE;
          end
        end else if (!chk_vld_q && scan_stop) begin
          res_d.status = STS_NO_FREE;
        end
      end
      S_FLOC: begin
        if (!(idx_q < base_next)) begin
          w_d    = w_q + WCNT_W'(1);
          base_d = base_next;
        end
      end
      S_FRD: begin
        mem_re = 1'b1;
      end
      S_FWR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q & ~(WORD_BITS'(1) << free_bit);
      end
      S_RESP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

// ===== hdl/bpa_ffz.sv =====
// ----------------------------------------------------------------------------
// bpa_ffz
// Find first zero: lowest clear bit of one bitmap word.
// ----------------------------------------------------------------------------
module bpa_ffz #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]         word_i,
  output logic                         found_o,
  output logic [$clog2(WORD_BITS)-1:0] idx_o,
  output logic [WORD_BITS-1:0]         onehot_o
);
  localparam int BIT_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] zeros;

  // isolate lowest set bit of the inverted word
  assign zeros    = ~word_i;
  assign onehot_o = zeros & (~zeros + WORD_BITS'(1));
  assign found_o  = |zeros;

  always_comb begin
    idx_o = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (onehot_o[b]) idx_o = idx_o | BIT_W'(b);
    end
  end

endmodule

// ===== hdl/bpa_checker.sv =====
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level assertions for the bitmap page allocator, bound to the top.
// ----------------------------------------------------------------------------
module bpa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bpa_pkg::res_t out_word_o
);
  import bpa_pkg::*;

  // a word with error status never carries a page number
  a_res_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != STS_OK) |-> out_word_o.page_number_res == '0)
    else $error("nonzero page number with error status");

  // one request in flight: busy right after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
